// ===== rtl/dzdh_pkg.sv =====
//------------------------------------------------------------------------------
// Dual-zone drum hit detector package
// Shared widths, register indexes, item types and small helpers.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dzdh_pkg;

  // Field widths fixed by the item format.
  localparam int SAMPLE_BITS    = 12;
  localparam int TIME_BITS      = 32;
  localparam int THRESH_BITS    = 12;
  localparam int SPAN_BITS      = 20;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 20;

  // Head wins unless the rim peak exceeds it by more than this margin.
  localparam logic [SAMPLE_BITS:0] HEAD_MARGIN = (SAMPLE_BITS + 1)'(100);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEAD_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RIM_THRESHOLD  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RETRIGGER_TIME = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCAN_TIME      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CROSSTALK_TIME = 3'd4;

  typedef enum logic [1:0] {
    HIT_NONE = 2'd0,
    HIT_HEAD = 2'd1,
    HIT_RIM  = 2'd2
  } hit_kind_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] head_sample;
    logic [SAMPLE_BITS-1:0] rim_sample;
    logic [TIME_BITS-1:0]   time_now;
  } sample_item_t;

  typedef struct packed {
    hit_kind_t              hit_kind;
    logic [SAMPLE_BITS-1:0] head_peak_out;
    logic [SAMPLE_BITS-1:0] rim_peak_out;
    logic [TIME_BITS-1:0]   hit_time;
  } hit_item_t;

  typedef struct packed {
    logic [THRESH_BITS-1:0] head_threshold;
    logic [THRESH_BITS-1:0] rim_threshold;
    logic [SPAN_BITS-1:0]   retrigger_time;
    logic [SPAN_BITS-1:0]   scan_time;
    logic [SPAN_BITS-1:0]   crosstalk_time;
  } cfg_t;

  // Zero-extend a microsecond span to the timestamp width.
  function automatic logic [TIME_BITS-1:0] span_to_time(input logic [SPAN_BITS-1:0] span);
    span_to_time = TIME_BITS'(span);
  endfunction

  // Zero-extend a threshold to the sample width.
  function automatic logic [SAMPLE_BITS-1:0] thresh_to_sample(
    input logic [THRESH_BITS-1:0] thr
  );
    thresh_to_sample = SAMPLE_BITS'(thr);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dzdh_cfg_regs.sv =====
//------------------------------------------------------------------------------
// Configuration registers
// Holds thresholds and time spans written through the plain write port.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dzdh_cfg_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 wr_en,
  input  wire logic [dzdh_pkg::CFG_INDEX_BITS-1:0]  wr_index,
  input  wire logic [dzdh_pkg::CFG_DATA_BITS-1:0]   wr_data,
  output dzdh_pkg::cfg_t                            cfg
);

  // Decode the index and load the addressed register; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        dzdh_pkg::REG_HEAD_THRESHOLD: begin
          cfg.head_threshold <= wr_data[dzdh_pkg::THRESH_BITS-1:0];
        end
        dzdh_pkg::REG_RIM_THRESHOLD: begin
          cfg.rim_threshold <= wr_data[dzdh_pkg::THRESH_BITS-1:0];
        end
        dzdh_pkg::REG_RETRIGGER_TIME: begin
          cfg.retrigger_time <= wr_data[dzdh_pkg::SPAN_BITS-1:0];
        end
        dzdh_pkg::REG_SCAN_TIME: begin
          cfg.scan_time <= wr_data[dzdh_pkg::SPAN_BITS-1:0];
        end
        dzdh_pkg::REG_CROSSTALK_TIME: begin
          cfg.crosstalk_time <= wr_data[dzdh_pkg::SPAN_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dzdh_hit_core.sv =====
//------------------------------------------------------------------------------
// Hit detection core
// Scan state, lockout timing and hit classification for one item per cycle while step is high.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dzdh_hit_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire dzdh_pkg::sample_item_t item,
  input  wire dzdh_pkg::cfg_t         cfg,
  output dzdh_pkg::hit_item_t         result
);

  localparam int SB = dzdh_pkg::SAMPLE_BITS;
  localparam int TB = dzdh_pkg::TIME_BITS;

  // Detector state.
  logic          scan_active;
  logic [TB-1:0] scan_start;
  logic [SB-1:0] head_peak;
  logic [SB-1:0] rim_peak;
  logic [TB-1:0] head_last_hit;
  logic [TB-1:0] rim_last_hit;

  logic          scan_active_next;
  logic [TB-1:0] scan_start_next;
  logic [SB-1:0] head_peak_next;
  logic [SB-1:0] rim_peak_next;
  logic [TB-1:0] head_last_hit_next;
  logic [TB-1:0] rim_last_hit_next;

  logic [TB-1:0] head_elapsed;
  logic [TB-1:0] rim_elapsed;
  logic [TB-1:0] retrigger;
  logic          head_fire;
  logic          rim_fire;
  logic [SB-1:0] head_max;
  logic [SB-1:0] rim_max;
  logic [TB-1:0] scan_dur;
  logic          scan_done;
  logic [TB-1:0] later;
  logic          head_wins;

  // Lockout test: elapsed time since last hit, read as signed.
  assign retrigger    = dzdh_pkg::span_to_time(cfg.retrigger_time);
  assign head_elapsed = item.time_now - head_last_hit;
  assign rim_elapsed  = item.time_now - rim_last_hit;
  assign head_fire    = (item.head_sample >= dzdh_pkg::thresh_to_sample(cfg.head_threshold))
                        && ($signed(head_elapsed) >= $signed(retrigger));
  assign rim_fire     = (item.rim_sample >= dzdh_pkg::thresh_to_sample(cfg.rim_threshold))
                        && ($signed(rim_elapsed) >= $signed(retrigger));

  // Peak tracking and scan timing.
  assign head_max  = (item.head_sample > head_peak) ? item.head_sample : head_peak;
  assign rim_max   = (item.rim_sample > rim_peak) ? item.rim_sample : rim_peak;
  assign scan_dur  = item.time_now - scan_start;
  assign scan_done = scan_dur >= dzdh_pkg::span_to_time(cfg.scan_time);
  assign later     = item.time_now + dzdh_pkg::span_to_time(cfg.crosstalk_time);
  assign head_wins = ({1'b0, head_max} + dzdh_pkg::HEAD_MARGIN) >= {1'b0, rim_max};

  // Next state and result for the current item.
  always_comb begin
    scan_active_next   = scan_active;
    scan_start_next    = scan_start;
    head_peak_next     = head_peak;
    rim_peak_next      = rim_peak;
    head_last_hit_next = head_last_hit;
    rim_last_hit_next  = rim_last_hit;
    result.hit_kind      = dzdh_pkg::HIT_NONE;
    result.head_peak_out = '0;
    result.rim_peak_out  = '0;
    result.hit_time      = item.time_now;
    if (!scan_active) begin
      if (head_fire || rim_fire) begin
        scan_active_next = 1'b1;
        scan_start_next  = item.time_now;
        head_peak_next   = item.head_sample;
        rim_peak_next    = item.rim_sample;
      end
    end else begin
      head_peak_next = head_max;
      rim_peak_next  = rim_max;
      if (scan_done) begin
        if (head_wins) begin
          result.hit_kind    = dzdh_pkg::HIT_HEAD;
          head_last_hit_next = item.time_now;
          rim_last_hit_next  = later;
        end else begin
          result.hit_kind    = dzdh_pkg::HIT_RIM;
          rim_last_hit_next  = item.time_now;
          head_last_hit_next = later;
        end
        result.head_peak_out = head_max;
        result.rim_peak_out  = rim_max;
        scan_active_next     = 1'b0;
        head_peak_next       = '0;
        rim_peak_next        = '0;
      end
    end
  end

  // State update, once per item that moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active   <= 1'b0;
      scan_start    <= '0;
      head_peak     <= '0;
      rim_peak      <= '0;
      head_last_hit <= '0;
      rim_last_hit  <= '0;
    end else if (step) begin
      scan_active   <= scan_active_next;
      scan_start    <= scan_start_next;
      head_peak     <= head_peak_next;
      rim_peak      <= rim_peak_next;
      head_last_hit <= head_last_hit_next;
      rim_last_hit  <= rim_last_hit_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dual_zone_drum_hit_detector.sv =====
// An accepted sample item reaches its hit item through the input register, then the
// result register; it is held there while the hit side stalls.
// Throughput: one item per cycle; the input register takes a new item whenever the
// result register is empty or being emptied in the same cycle.
// Reset (synchronous, active high) clears the configuration registers, the scan state, the
// last-hit times and both valid flags.
//------------------------------------------------------------------------------
// Dual-zone drum hit detector
// Head and rim piezo trigger with peak scan, retrigger lockout and crosstalk
// exclusion; one hit item out for every sample item in.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_zone_drum_hit_detector (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 wr_en,
  input  wire logic [dzdh_pkg::CFG_INDEX_BITS-1:0]  wr_index,
  input  wire logic [dzdh_pkg::CFG_DATA_BITS-1:0]   wr_data,
  input  wire logic                                 sample_valid,
  output logic                                      sample_stall,
  input  wire dzdh_pkg::sample_item_t               sample,
  output logic                                      hit_valid,
  input  wire logic                                 hit_stall,
  output dzdh_pkg::hit_item_t                       hit
);

  dzdh_pkg::cfg_t         cfg;
  dzdh_pkg::sample_item_t in_reg;
  logic                   in_reg_valid;
  dzdh_pkg::hit_item_t    result;
  logic                   advance;
  logic                   res_free;

  dzdh_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  // The result register can load when it is empty or its item leaves now.
  assign res_free     = !hit_valid || !hit_stall;
  assign advance      = in_reg_valid && res_free;
  assign sample_stall = in_reg_valid && !res_free;

  dzdh_hit_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_reg),
    .cfg    (cfg),
    .result (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!sample_stall) begin
      in_reg_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      in_reg <= sample;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (res_free) begin
      hit_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit <= result;
    end
  end

  // A no-hit item carries zero peaks.
  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    (hit_valid && hit.hit_kind == dzdh_pkg::HIT_NONE)
      |-> (hit.head_peak_out == '0 && hit.rim_peak_out == '0))
    else $error("no-hit item with nonzero peaks");

  // A head hit respects the head margin.
  a_head_margin: assert property (@(posedge clk) disable iff (rst)
    (hit_valid && hit.hit_kind == dzdh_pkg::HIT_HEAD)
      |-> (({1'b0, hit.head_peak_out} + dzdh_pkg::HEAD_MARGIN) >= {1'b0, hit.rim_peak_out}))
    else $error("head hit classified against the margin");

  // A rim hit means the rim peak beat the head margin.
  a_rim_margin: assert property (@(posedge clk) disable iff (rst)
    (hit_valid && hit.hit_kind == dzdh_pkg::HIT_RIM)
      |-> (({1'b0, hit.head_peak_out} + dzdh_pkg::HEAD_MARGIN) < {1'b0, hit.rim_peak_out}))
    else $error("rim hit classified against the margin");

  // The input side is only held back while the result register is full and stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (hit_valid && hit_stall && in_reg_valid))
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
